// ===== rtl/core/arg_pkg.sv =====
// Shared types and constants for the allele run grouper.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package arg_pkg;

    // Suffix array index bits that count (32 or more keeps the whole field); the rest of the 32-bit field is dropped.
    localparam int INDEX_BITS = 32;

    localparam logic [31:0] POS_MASK =
        (INDEX_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << INDEX_BITS) - 64'd1);

    localparam int IN_DATA_BITS  = 96;
    localparam int OUT_DATA_BITS = 128;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic        final_run;
        logic        inside_site;
        logic [31:0] run_allele;
        logic [31:0] run_site;
        logic [31:0] run_end;
        logic [31:0] run_start;
    } run_t;

    // Up to two runs per item, in delivery order.
    typedef struct packed {
        logic first_valid;
        logic second_valid;
        run_t first;
        run_t second;
    } run_pair_t;

endpackage : arg_pkg

`default_nettype wire

// ===== rtl/core/arg_merge.sv =====
// Run merge logic: holds the open run and works out the runs one position closes.
// Depends on arg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arg_merge
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [31:0]      sa_position,
    input  wire logic [31:0]      site_code,
    input  wire logic [31:0]      allele_num,
    input  wire logic             last_position,
    output arg_pkg::run_pair_t    runs
);
    import arg_pkg::*;

    logic        held_valid_reg, held_valid_next;
    logic [31:0] held_start_reg, held_start_next;
    logic [31:0] held_end_reg,   held_end_next;
    logic [31:0] held_site_reg,  held_site_next;
    logic [31:0] held_allele_reg, held_allele_next;

    logic [31:0] pos;
    logic        outside;
    logic        match;
    run_t        held_run;
    run_t        new_run;
    logic        held_out;
    logic        new_out;

    always_comb
    begin
        pos     = sa_position & POS_MASK;
        outside = (site_code == 32'd0);
        match   = held_valid_reg && (site_code == held_site_reg)
                  && (allele_num == held_allele_reg);

        // held run leaves on an outside position or on a site/allele change
        held_out = held_valid_reg && (outside || !match);

        held_run.run_start   = held_start_reg;
        held_run.run_end     = held_end_reg;
        held_run.run_site    = held_site_reg;
        held_run.run_allele  = held_allele_reg;
        held_run.inside_site = 1'b1;
        held_run.final_run   = 1'b0;

        if (outside)
        begin
            new_run.run_start   = pos;
            new_run.run_site    = 32'd0;
            new_run.run_allele  = 32'd0;
            new_run.inside_site = 1'b0;
        end
        else
        begin
            new_run.run_start   = match ? held_start_reg : pos;
            new_run.run_site    = site_code;
            new_run.run_allele  = allele_num;
            new_run.inside_site = 1'b1;
        end
        new_run.run_end   = pos;
        new_run.final_run = last_position;
        new_out = outside || last_position;

        // compact so that a lone run always sits in the first slot
        runs.first_valid  = held_out || new_out;
        runs.second_valid = held_out && new_out;
        runs.first        = held_out ? held_run : new_run;
        runs.second       = new_run;

        held_valid_next  = held_valid_reg;
        held_start_next  = held_start_reg;
        held_end_next    = held_end_reg;
        held_site_next   = held_site_reg;
        held_allele_next = held_allele_reg;
        if (accept)
        begin
            if (outside)
            begin
                held_valid_next = 1'b0;
            end
            else
            begin
                held_end_next = pos;
                if (!match)
                begin
                    held_start_next  = pos;
                    held_site_next   = site_code;
                    held_allele_next = allele_num;
                end
                held_valid_next = !last_position;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg  <= 1'b0;
            held_start_reg  <= 32'd0;
            held_end_reg    <= 32'd0;
            held_site_reg   <= 32'd0;
            held_allele_reg <= 32'd0;
        end
        else
        begin
            held_valid_reg  <= held_valid_next;
            held_start_reg  <= held_start_next;
            held_end_reg    <= held_end_next;
            held_site_reg   <= held_site_next;
            held_allele_reg <= held_allele_next;
        end
    end

endmodule : arg_merge

`default_nettype wire

// ===== rtl/core/arg_out_fifo.sv =====
// Result queue: takes up to two runs per cycle, hands out one per cycle while out_ready is high.
// Depends on arg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arg_out_fifo
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire arg_pkg::run_pair_t runs,
    output logic                  room2,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output arg_pkg::run_t         out_run
);
    import arg_pkg::*;

    run_t                entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]  count_reg, count_next;
    logic [FIFO_CW-1:0]  n_in;
    logic                pop;
    logic [FIFO_AW-1:0]  wr_ptr_p1;

    always_comb
    begin
        room2     = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
        out_valid = (count_reg != '0);
        out_run   = entry_reg[rd_ptr_reg];
        pop       = out_valid && out_ready;
        wr_ptr_p1 = wr_ptr_reg + FIFO_AW'(1);

        n_in = '0;
        if (push)
        begin
            n_in = FIFO_CW'(runs.first_valid) + FIFO_CW'(runs.second_valid);
        end

        wr_ptr_next = wr_ptr_reg + n_in[FIFO_AW-1:0];
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + n_in - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && runs.first_valid)
        begin
            entry_reg[wr_ptr_reg] <= runs.first;
        end
        if (push && runs.second_valid)
        begin
            entry_reg[wr_ptr_p1] <= runs.second;
        end
    end

endmodule : arg_out_fifo

`default_nettype wire

// ===== rtl/core/allele_run_grouper_top.sv =====
// Allele run grouper top level: stream ports, merge logic and result queue.
// Depends on arg_pkg, arg_merge and arg_out_fifo.
//
// Usage:
//   The slave channel (s_tvalid/s_tready/s_tdata/s_tlast) takes one suffix
//   array position per item with its site marker and allele number; s_tlast
//   marks the last position of the interval. The master channel delivers runs:
//   start, end, site and allele in m_tdata, inside-site flag in m_tuser,
//   and m_tlast on the final run of the interval.
//   An item yields zero, one or two runs. They land in a four-entry result
//   queue at the edge that accepts the item; the queue is registered, and
//   they show on the master side behind any runs already queued.
//   Throughput: one item per cycle while the queue has room for two runs;
//   the queue drains one run per cycle while m_tready is high, so items
//   yielding two runs slow the input to the output rate.
//   Reset clears the held run and empties the queue; the first item after
//   reset starts a new interval, as does the item after the one with s_tlast.
//   When the receiver stalls, the queue fills and s_tready drops once fewer
//   than two entries are free; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module allele_run_grouper_top
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // sa_position, site_code, allele_num
    input  wire logic         s_tlast,   // last_position
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // run_start, run_end, run_site, run_allele
    output logic              m_tuser,   // inside_site
    output logic              m_tlast    // final_run
);
    import arg_pkg::*;

    logic      accept;
    run_pair_t runs;
    run_t      out_run;
    logic      room2;

    assign accept = s_tvalid && s_tready;
    assign s_tready = room2;

    arg_merge u_merge
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .sa_position   (s_tdata[31:0]),
        .site_code     (s_tdata[63:32]),
        .allele_num    (s_tdata[95:64]),
        .last_position (s_tlast),
        .runs          (runs)
    );

    arg_out_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .runs      (runs),
        .room2     (room2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_run   (out_run)
    );

    assign m_tdata = {out_run.run_allele, out_run.run_site, out_run.run_end, out_run.run_start};
    assign m_tuser = out_run.inside_site;
    assign m_tlast = out_run.final_run;

endmodule : allele_run_grouper_top

`default_nettype wire
